// ----- sv/tth_pkg.sv -----
package tth_pkg;

  localparam int HASH_BITS   = 10;
  localparam int TITLE_BYTES = 64;
  localparam int SLOTS       = 1 << HASH_BITS;
  localparam int IDX_W       = $clog2(TITLE_BYTES);
  localparam int LEN_W       = $clog2(TITLE_BYTES + 1);
  localparam int CNT_W       = HASH_BITS + 1;
  localparam int ID_W        = 31;
  localparam int TADDR_W     = HASH_BITS + IDX_W;

  localparam logic [7:0] RE_PFX [4] = '{8'h52, 8'h65, 8'h3A, 8'h20};

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_INSERT
  } state_t;

  typedef struct packed {
    logic buf_wr;
    logic key_init;
    logic len_clr;
    logic clr_init;
    logic clr_step;
    logic slot_rd;
    logic probe_next;
    logic idx_clr;
    logic byte_rd;
    logic idx_inc;
    logic title_wr;
    logic ent_wr;
    logic emit;
    logic emit_matched;
    logic emit_full;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic slot_empty;
    logic slot_hit;
    logic key_empty;
    logic probe_last;
    logic byte_eq;
    logic idx_last;
  } stat_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [LEN_W-1:0]     len;
    logic [ID_W-1:0]      id;
  } entry_t;

endpackage

// ----- sv/tth_ctrl.sv -----
module tth_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_mode,
  input  logic          char_zero,
  input  tth_pkg::stat_t stat,
  output tth_pkg::cmd_t  cmd,
  output logic          busy
);

  tth_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tth_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != tth_pkg::S_IDLE);
    unique case (state_r)
      tth_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = tth_pkg::S_IDLE;
        end
      end
      tth_pkg::S_IDLE: begin
        if (start) begin
          if (in_mode) begin
            cmd.len_clr  = 1'b1;
            cmd.clr_init = 1'b1;
            state_nxt    = tth_pkg::S_CLEAR;
          end else if (!char_zero) begin
            cmd.buf_wr = 1'b1;
          end else begin
            cmd.key_init = 1'b1;
            state_nxt    = tth_pkg::S_PROBE_RD;
          end
        end
      end
      tth_pkg::S_PROBE_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = tth_pkg::S_PROBE_CHK;
      end
      tth_pkg::S_PROBE_CHK: begin
        cmd.idx_clr = 1'b1;
        if (stat.slot_empty) begin
          state_nxt = stat.key_empty ? tth_pkg::S_INSERT : tth_pkg::S_COPY_RD;
        end else if (stat.slot_hit) begin
          if (stat.key_empty) begin
            cmd.emit         = 1'b1;
            cmd.emit_matched = 1'b1;
            state_nxt        = tth_pkg::S_IDLE;
          end else begin
            state_nxt = tth_pkg::S_CMP_RD;
          end
        end else if (stat.probe_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_full = 1'b1;
          state_nxt     = tth_pkg::S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = tth_pkg::S_PROBE_RD;
        end
      end
      tth_pkg::S_CMP_RD: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = tth_pkg::S_CMP_CHK;
      end
      tth_pkg::S_CMP_CHK: begin
        if (!stat.byte_eq) begin
          if (stat.probe_last) begin
            cmd.emit      = 1'b1;
            cmd.emit_full = 1'b1;
            state_nxt     = tth_pkg::S_IDLE;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = tth_pkg::S_PROBE_RD;
          end
        end else if (stat.idx_last) begin
          cmd.emit         = 1'b1;
          cmd.emit_matched = 1'b1;
          state_nxt        = tth_pkg::S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = tth_pkg::S_CMP_RD;
        end
      end
      tth_pkg::S_COPY_RD: begin
        cmd.byte_rd = 1'b1;
        state_nxt   = tth_pkg::S_COPY_WR;
      end
      tth_pkg::S_COPY_WR: begin
        cmd.title_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = stat.idx_last ? tth_pkg::S_INSERT : tth_pkg::S_COPY_RD;
      end
      tth_pkg::S_INSERT: begin
        cmd.ent_wr = 1'b1;
        cmd.emit   = 1'b1;
        state_nxt  = tth_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tth_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/tth_dp.sv -----
module tth_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tth_pkg::cmd_t            cmd,
  input  logic [7:0]               in_char_byte,
  input  logic [tth_pkg::ID_W-1:0] in_post_id,
  output tth_pkg::stat_t           stat,
  output logic                     out_valid,
  output logic [tth_pkg::ID_W-1:0] out_thread_id,
  output logic                     out_matched,
  output logic                     out_table_full
);

  localparam int HB = tth_pkg::HASH_BITS;

  tth_pkg::entry_t slot_mem [tth_pkg::SLOTS];
  logic [7:0]      title_mem [1 << tth_pkg::TADDR_W];
  logic [7:0]      buf_mem [tth_pkg::TITLE_BYTES];

  logic [tth_pkg::LEN_W-1:0] len_r;
  logic [HB-1:0]             h_all_r, h_str_r;
  logic                      pfx_r;
  logic [tth_pkg::LEN_W-1:0] key_len_r;
  logic [HB-1:0]             key_hash_r;
  logic                      strip_r;
  logic [tth_pkg::ID_W-1:0]  pid_r;
  logic [HB-1:0]             pos_r;
  logic [tth_pkg::CNT_W-1:0] cnt_r;
  logic [tth_pkg::IDX_W-1:0] idx_r;
  tth_pkg::entry_t           slot_q;
  logic [7:0]                title_q, buf_q;
  logic                      out_valid_r, out_matched_r, out_full_r;
  logic [tth_pkg::ID_W-1:0]  out_id_r;

  logic                      strip;
  logic [tth_pkg::IDX_W-1:0] buf_raddr;
  logic [tth_pkg::TADDR_W-1:0] taddr;
  logic [tth_pkg::LEN_W-1:0] idx_p1;

  assign strip     = (len_r >= tth_pkg::LEN_W'(4)) && pfx_r;
  assign buf_raddr = idx_r + (strip_r ? tth_pkg::IDX_W'(4) : '0);
  assign taddr     = {pos_r, idx_r};
  assign idx_p1    = {1'b0, idx_r} + tth_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      h_all_r <= '0;
      h_str_r <= '0;
      pfx_r   <= 1'b1;
    end else if (cmd.len_clr || cmd.key_init) begin
      len_r   <= '0;
      h_all_r <= '0;
      h_str_r <= '0;
      pfx_r   <= 1'b1;
    end else if (cmd.buf_wr && len_r < tth_pkg::LEN_W'(tth_pkg::TITLE_BYTES)) begin
      len_r   <= len_r + tth_pkg::LEN_W'(1);
      h_all_r <= (h_all_r << 5) - h_all_r + HB'(in_char_byte);
      if (len_r >= tth_pkg::LEN_W'(4)) begin
        h_str_r <= (h_str_r << 5) - h_str_r + HB'(in_char_byte);
      end else if (in_char_byte != tth_pkg::RE_PFX[len_r[1:0]]) begin
        pfx_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_wr && len_r < tth_pkg::LEN_W'(tth_pkg::TITLE_BYTES)) begin
      buf_mem[len_r[tth_pkg::IDX_W-1:0]] <= in_char_byte;
    end
    if (cmd.byte_rd) begin
      buf_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_init) begin
      strip_r    <= strip;
      key_len_r  <= strip ? len_r - tth_pkg::LEN_W'(4) : len_r;
      key_hash_r <= strip ? h_str_r : h_all_r;
      pid_r      <= in_post_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.clr_init) begin
        cnt_r <= '0;
      end else if (cmd.clr_step || cmd.probe_next) begin
        cnt_r <= cnt_r + tth_pkg::CNT_W'(1);
      end else if (cmd.key_init) begin
        cnt_r <= '0;
      end
      if (cmd.key_init) begin
        pos_r <= strip ? h_str_r : h_all_r;
      end else if (cmd.probe_next) begin
        pos_r <= pos_r + HB'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + tth_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      slot_mem[cnt_r[HB-1:0]] <= '0;
    end else if (cmd.ent_wr) begin
      slot_mem[pos_r] <= '{hash: key_hash_r, len: key_len_r, id: pid_r};
    end
    if (cmd.slot_rd) begin
      slot_q <= slot_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.title_wr) begin
      title_mem[taddr] <= buf_q;
    end
    if (cmd.byte_rd) begin
      title_q <= title_mem[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_matched_r <= cmd.emit_matched;
      out_full_r    <= cmd.emit_full;
      out_id_r      <= cmd.emit_matched ? slot_q.id : pid_r;
    end
  end

  always_comb begin
    stat.clr_last   = (cnt_r[HB-1:0] == HB'(tth_pkg::SLOTS - 1));
    stat.slot_empty = (slot_q.hash == '0);
    stat.slot_hit   = (slot_q.hash == key_hash_r) && (slot_q.len == key_len_r);
    stat.key_empty  = (key_len_r == '0);
    stat.probe_last = (cnt_r == tth_pkg::CNT_W'(tth_pkg::SLOTS - 1));
    stat.byte_eq    = (title_q == buf_q);
    stat.idx_last   = (idx_p1 == key_len_r);
  end

  assign out_valid      = out_valid_r;
  assign out_thread_id  = out_id_r;
  assign out_matched    = out_matched_r;
  assign out_table_full = out_full_r;

endmodule

// ----- sv/title_thread_hash_table.sv -----
// Assigns thread ids to post titles with an open-addressing hash table.
// A request is taken when start is high and busy is low. With in_mode low,
// in_char_byte is one title byte; a zero byte ends the title and in_post_id
// gives the post's id. With in_mode high the whole table is cleared.
// A title byte leaves busy low, so bytes may follow back to back. The
// ending byte strips a leading "Re: ", then probes the table slot by slot,
// reading each slot and then checking it, comparing the stored title byte
// by byte on a hash and length hit, and fills a new slot by copying the key
// bytes and writing the entry. The result is registered after the last step,
// marked by out_valid for exactly one cycle. The receiver cannot stall it.
// out_thread_id is the earlier post's id on a match, otherwise in_post_id;
// out_table_full is set when no slot matched and none was free.
// After reset, and after each clear request, a clearing pass over the
// 1024 slots runs with busy high.
module title_thread_hash_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [7:0]               in_char_byte,
  input  logic [tth_pkg::ID_W-1:0] in_post_id,
  output logic                     out_valid,
  output logic [tth_pkg::ID_W-1:0] out_thread_id,
  output logic                     out_matched,
  output logic                     out_table_full
);

  tth_pkg::cmd_t  cmd;
  tth_pkg::stat_t stat;

  tth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .char_zero (in_char_byte == 8'h00),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  tth_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_char_byte   (in_char_byte),
    .in_post_id     (in_post_id),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_thread_id  (out_thread_id),
    .out_matched    (out_matched),
    .out_table_full (out_table_full)
  );

endmodule

// ----- test/title_thread_hash_table_check.sv -----
`timescale 1ns / 100ps

module title_thread_hash_table_check (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_mode,
  input  logic [7:0]               in_char_byte,
  input  logic [tth_pkg::ID_W-1:0] in_post_id,
  input  logic                     out_valid,
  input  logic [tth_pkg::ID_W-1:0] out_thread_id,
  input  logic                     out_matched,
  input  logic                     out_table_full,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic [tth_pkg::ID_W-1:0] id;
    logic                     matched;
    logic                     full;
  } thread_t;

  thread_t                       expected_threads[$];
  logic [tth_pkg::HASH_BITS-1:0] tab_hash[tth_pkg::SLOTS];
  logic [tth_pkg::ID_W-1:0]      tab_id[tth_pkg::SLOTS];
  logic [7:0]                    tab_title[tth_pkg::SLOTS][tth_pkg::TITLE_BYTES];
  logic [7:0]                    line_buf[tth_pkg::TITLE_BYTES];
  int                            line_len;

  initial begin
    errors = 0;
    pending = 0;
    line_len = 0;
  end

  function automatic void clear_slots();
    for (int s = 0; s < tth_pkg::SLOTS; s++) begin
      tab_hash[s] = '0;
      tab_id[s] = '0;
    end
    line_len = 0;
  endfunction

  // Strips the reply prefix, hashes the key and probes the table, inserting on a miss.
  function automatic thread_t assign_thread(logic [tth_pkg::ID_W-1:0] pid);
    int first;
    int p;
    bit same;
    logic [31:0] h;
    logic [tth_pkg::HASH_BITS-1:0] hm;
    logic [7:0] key[tth_pkg::TITLE_BYTES];
    thread_t v;
    first = 0;
    h = '0;
    if (line_len >= 4 && line_buf[0] == tth_pkg::RE_PFX[0] &&
        line_buf[1] == tth_pkg::RE_PFX[1] && line_buf[2] == tth_pkg::RE_PFX[2] &&
        line_buf[3] == tth_pkg::RE_PFX[3]) begin
      first = 4;
    end
    for (int i = 0; i < tth_pkg::TITLE_BYTES; i++) key[i] = 8'h00;
    for (int i = first; i < line_len; i++) begin
      key[i - first] = line_buf[i];
      h = h * 32'd31 + {24'h0, line_buf[i]};
    end
    line_len = 0;
    hm = h[tth_pkg::HASH_BITS-1:0];
    p = int'(hm);
    v = '{id: pid, matched: 1'b0, full: 1'b1};
    for (int n = 0; n < tth_pkg::SLOTS; n++) begin
      if (tab_hash[p] == '0) begin
        tab_hash[p] = hm;
        tab_id[p] = pid;
        for (int i = 0; i < tth_pkg::TITLE_BYTES; i++) tab_title[p][i] = key[i];
        v.full = 1'b0;
        return v;
      end
      if (tab_hash[p] == hm) begin
        same = 1;
        for (int i = 0; i < tth_pkg::TITLE_BYTES; i++) begin
          if (tab_title[p][i] != key[i]) same = 0;
        end
        if (same) return '{id: tab_id[p], matched: 1'b1, full: 1'b0};
      end
      p = (p + 1) % tth_pkg::SLOTS;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    thread_t want;
    if (!rst_n) begin
      clear_slots();
      expected_threads.delete();
    end else begin
      if (start && !busy) begin
        if (in_mode) begin
          clear_slots();
        end else if (in_char_byte != 8'h00) begin
          if (line_len < tth_pkg::TITLE_BYTES) begin
            line_buf[line_len] = in_char_byte;
            line_len++;
          end
        end else begin
          expected_threads.push_back(assign_thread(in_post_id));
        end
      end
      if (out_valid) begin
        if (expected_threads.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Result with no request pending: id=%0h", out_thread_id);
        end else begin
          want = expected_threads.pop_front();
          if (out_thread_id != want.id || out_matched != want.matched ||
              out_table_full != want.full) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch: expected id=%0h matched=%0b full=%0b,",
                       want.id, want.matched, want.full,
                       " got id=%0h matched=%0b full=%0b",
                       out_thread_id, out_matched, out_table_full);
            end
          end
        end
      end
    end
    pending <= expected_threads.size();
  end

endmodule

// ----- test/title_thread_hash_table_test.sv -----
`timescale 1ns / 100ps

module title_thread_hash_table_test;

  typedef logic [7:0] text_t[$];

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_mode;
  logic [7:0]               in_char_byte;
  logic [tth_pkg::ID_W-1:0] in_post_id;
  logic                     out_valid;
  logic [tth_pkg::ID_W-1:0] out_thread_id;
  logic                     out_matched;
  logic                     out_table_full;
  int                       errors;
  int                       pending;
  int                       sent;
  bit                       idling;
  text_t                    pool[16];

  title_thread_hash_table dut (.*);

  title_thread_hash_table_check checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic put(input logic mode, input logic [7:0] ch,
                     input logic [tth_pkg::ID_W-1:0] pid);
    while (idling && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_char_byte <= ch;
    in_post_id <= pid;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic send_title(input text_t t, input logic [tth_pkg::ID_W-1:0] pid);
    foreach (t[i]) put(1'b0, t[i], tth_pkg::ID_W'($urandom()));
    put(1'b0, 8'h00, pid);
  endtask

  function automatic text_t from_string(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic text_t random_text(int n);
    text_t t;
    for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(1, 255)));
    return t;
  endfunction

  // Two bytes whose hash lands exactly on the given slot; skip picks another pair.
  function automatic text_t text_for_slot(int slot, int skip);
    text_t t;
    int b;
    for (int a = 1; a < 256; a++) begin
      b = (slot - 31 * a) & (tth_pkg::SLOTS - 1);
      if (b >= 1 && b <= 255) begin
        if (skip == 0) begin
          t.push_back(8'(a));
          t.push_back(8'(b));
          return t;
        end
        skip--;
      end
    end
    return t;
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    text_t long_a, long_b, t, no_text;
    rst_n = 0;
    start = 0;
    in_mode = 0;
    in_char_byte = 0;
    in_post_id = 0;
    sent = 0;
    idling = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_title(from_string("hello"), 31'h7FFFFFFF);
    send_title(from_string("Re: hello"), 31'd5);
    send_title(from_string("Re:"), 31'd0);
    send_title(from_string("Re: "), 31'd7);
    send_title(no_text, 31'd8);
    send_title(text_t'{8'd33, 8'd1}, 31'd9);
    send_title(text_t'{8'd33, 8'd1}, 31'd10);
    long_a = random_text(70);
    long_a[0] = 8'hFF;
    long_b = long_a;
    long_b[66] = long_b[66] ^ 8'h80;
    long_b.push_back(8'h01);
    send_title(long_a, 31'h2AAAAAAA);
    send_title(long_b, 31'h55555555);
    put(1'b0, "a", 31'd1);
    put(1'b0, "b", 31'd2);
    put(1'b1, 8'h00, 31'd3);
    send_title(from_string("xyz"), 31'd11);
    send_title(from_string("hello"), 31'd12);

    foreach (pool[i]) pool[i] = random_text($urandom_range(99) < 10 ?
                                            $urandom_range(60, 72) : $urandom_range(1, 12));
    while (sent < 385) begin
      idling = !(sent > 200 && sent < 300);
      if (sent > 250 && sent < 260) drain();
      if ($urandom_range(99) < 3) begin
        put(1'b1, 8'($urandom()), tth_pkg::ID_W'($urandom()));
      end else if ($urandom_range(99) < 10) begin
        send_title(random_text($urandom_range(0, 8)), tth_pkg::ID_W'($urandom()));
      end else begin
        t = pool[$urandom_range(15)];
        if ($urandom_range(99) < 30) t = {from_string("Re: "), t};
        send_title(t, tth_pkg::ID_W'($urandom()));
      end
    end

    // Titles that collide on the last slot wrap around into the first slots.
    put(1'b1, 8'h00, 31'd0);
    idling = 1;
    send_title(text_for_slot(tth_pkg::SLOTS - 1, 0), tth_pkg::ID_W'($urandom()));
    send_title(text_for_slot(tth_pkg::SLOTS - 1, 1), tth_pkg::ID_W'($urandom()));
    send_title(text_for_slot(tth_pkg::SLOTS - 1, 2), tth_pkg::ID_W'($urandom()));
    send_title(text_for_slot(1, 0), tth_pkg::ID_W'($urandom()));
    send_title(text_for_slot(tth_pkg::SLOTS - 1, 2), tth_pkg::ID_W'($urandom()));

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
